/* hdl/u8v_pkg.sv */
// Shared types and constants for the UTF-8 stream validator.
package u8v_pkg;

	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_LEAD2 = 3'd1,
		CLS_LEAD3 = 3'd2,
		CLS_LEAD4 = 3'd3,
		CLS_CONT  = 3'd4,
		CLS_BAD   = 3'd5
	} byte_class_t;

	typedef struct packed {
		logic        is_last;
		logic        no_byte;
		byte_class_t cls;
		logic [5:0]  bits;
	} item_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} queue_status_t;

	localparam int CODE_W = 21;

	localparam logic [1:0] SEQ_NONE = 2'd0;
	localparam logic [1:0] SEQ_TWO  = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR = 2'd3;

	localparam logic [CODE_W-1:0] MIN_TWO       = 21'h000080;
	localparam logic [CODE_W-1:0] MIN_THREE     = 21'h000800;
	localparam logic [CODE_W-1:0] MIN_FOUR      = 21'h010000;
	localparam logic [CODE_W-1:0] CODE_MAX      = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SURR_LOW      = 21'h00D800;
	localparam logic [CODE_W-1:0] SURR_HIGH     = 21'h00DFFF;

endpackage

/* hdl/u8v_front.sv */
// Front end: accepts input words and classifies each byte for the queue.
module u8v_front (
	input  logic              valid,
	output logic              stall,
	input  logic [7:0]        data_byte,
	input  logic              is_last,
	input  logic              no_byte,
	input  u8v_pkg::queue_status_t status,
	output logic              push,
	output u8v_pkg::item_t    item
);

	assign stall = status.full;
	assign push  = valid && !status.full;

	always_comb begin
		item.is_last = is_last;
		item.no_byte = no_byte;
		item.cls     = u8v_pkg::CLS_BAD;
		item.bits    = data_byte[5:0];
		if (data_byte[7] == 1'b0) begin
			item.cls  = u8v_pkg::CLS_ASCII;
		end else if (data_byte[7:6] == 2'b10) begin
			item.cls  = u8v_pkg::CLS_CONT;
		end else if (data_byte[7:5] == 3'b110) begin
			item.cls  = u8v_pkg::CLS_LEAD2;
			item.bits = {1'b0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			item.cls  = u8v_pkg::CLS_LEAD3;
			item.bits = {2'b00, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			item.cls  = u8v_pkg::CLS_LEAD4;
			item.bits = {3'b000, data_byte[2:0]};
		end
	end

endmodule

/* hdl/u8v_queue.sv */
// Short queue of classified words between the front and back ends.
module u8v_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  u8v_pkg::item_t         push_item,
	input  logic                   pop,
	output u8v_pkg::queue_status_t status,
	output u8v_pkg::item_t         head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8v_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full       = (count_q == CNT_W'(DEPTH));
	assign status.head_valid = (count_q != '0);
	assign head_item         = mem_q[rd_ptr_q];
	assign do_push           = push && !status.full;
	assign do_pop            = pop && status.head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hdl/u8v_back.sv */
// Back end: sequence state, code point checks and the result register.
module u8v_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8v_pkg::queue_status_t status,
	input  u8v_pkg::item_t         head_item,
	output logic                   pop,
	output logic                   valid,
	input  logic                   stall,
	output logic                   string_valid
);

	logic [1:0]                  pend_q;
	logic [1:0]                  len_q;
	logic [u8v_pkg::CODE_W-1:0]  acc_q;
	logic                        err_q;
	logic                        valid_q;
	logic                        string_valid_q;

	logic [1:0]                  n_pend;
	logic [1:0]                  n_len;
	logic [u8v_pkg::CODE_W-1:0]  n_acc;
	logic                        n_err;
	logic [u8v_pkg::CODE_W-1:0]  acc_shift;
	logic                        bad_code;
	logic                        out_free;

	assign out_free     = !valid_q || !stall;
	assign pop          = status.head_valid && out_free;
	assign valid        = valid_q;
	assign string_valid = string_valid_q;
	assign acc_shift    = {acc_q[u8v_pkg::CODE_W-7:0], head_item.bits};

	always_comb begin
		bad_code = 1'b0;
		if (len_q == u8v_pkg::SEQ_TWO && acc_shift < u8v_pkg::MIN_TWO) begin
			bad_code = 1'b1;
		end
		if (len_q == u8v_pkg::SEQ_THREE && acc_shift < u8v_pkg::MIN_THREE) begin
			bad_code = 1'b1;
		end
		if (len_q == u8v_pkg::SEQ_FOUR && acc_shift < u8v_pkg::MIN_FOUR) begin
			bad_code = 1'b1;
		end
		if (acc_shift > u8v_pkg::CODE_MAX) begin
			bad_code = 1'b1;
		end
		if (acc_shift >= u8v_pkg::SURR_LOW && acc_shift <= u8v_pkg::SURR_HIGH) begin
			bad_code = 1'b1;
		end
	end

	always_comb begin
		n_pend = pend_q;
		n_len  = len_q;
		n_acc  = acc_q;
		n_err  = err_q;
		if (!head_item.no_byte && !err_q) begin
			if (pend_q == 2'd0) begin
				case (head_item.cls)
					u8v_pkg::CLS_ASCII: begin
					end
					u8v_pkg::CLS_LEAD2: begin
						n_acc  = u8v_pkg::CODE_W'(head_item.bits);
						n_len  = u8v_pkg::SEQ_TWO;
						n_pend = u8v_pkg::SEQ_TWO;
					end
					u8v_pkg::CLS_LEAD3: begin
						n_acc  = u8v_pkg::CODE_W'(head_item.bits);
						n_len  = u8v_pkg::SEQ_THREE;
						n_pend = u8v_pkg::SEQ_THREE;
					end
					u8v_pkg::CLS_LEAD4: begin
						n_acc  = u8v_pkg::CODE_W'(head_item.bits);
						n_len  = u8v_pkg::SEQ_FOUR;
						n_pend = u8v_pkg::SEQ_FOUR;
					end
					default: begin
						n_err = 1'b1;
					end
				endcase
			end else if (head_item.cls != u8v_pkg::CLS_CONT) begin
				n_err  = 1'b1;
				n_pend = 2'd0;
			end else begin
				n_pend = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					n_err = bad_code;
					n_len = u8v_pkg::SEQ_NONE;
					n_acc = '0;
				end else begin
					n_acc = acc_shift;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_item.is_last) begin
					pend_q <= '0;
					len_q  <= '0;
					acc_q  <= '0;
					err_q  <= 1'b0;
				end else begin
					pend_q <= n_pend;
					len_q  <= n_len;
					acc_q  <= n_acc;
					err_q  <= n_err;
				end
			end
			if (out_free) begin
				valid_q <= pop && head_item.is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.is_last) begin
			string_valid_q <= !n_err && (n_pend == 2'd0);
		end
	end

endmodule

/* hdl/utf8_stream_validator_core.sv */
// Top level of the UTF-8 stream validator.
// The block checks a string, one byte per input word, for well-formed UTF-8.
// Input channel: in_valid with in_stall carries data_byte, is_last and no_byte.
// A word with is_last high ends the string; no_byte marks a word without a byte.
// Output channel: out_valid with out_stall carries string_valid, one word for
// each string, given after the word that ends it.
// The front end classifies each byte as it is accepted and writes it into a
// short queue; the back end takes one queued word a cycle while the output
// register is free, updates the sequence state and loads the output register.
// Throughput is one byte per cycle without stalls; the back-end update is the loop.
// The last byte is held in the queue, then its result in the output register.
// When the receiver stalls, the result holds in the output register and the
// queue fills; in_stall rises only when the queue is full.
// Reset clears the sequence state, the queue pointers and out_valid, and
// the block accepts words from the first cycle after reset.
module utf8_stream_validator_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	input  logic       no_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       string_valid
);

	u8v_pkg::queue_status_t status;
	u8v_pkg::item_t         push_item;
	u8v_pkg::item_t         head_item;
	logic                   push;
	logic                   pop;

	u8v_front u_front (
		.valid     (in_valid),
		.stall     (in_stall),
		.data_byte (data_byte),
		.is_last   (is_last),
		.no_byte   (no_byte),
		.status    (status),
		.push      (push),
		.item      (push_item)
	);

	u8v_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.status    (status),
		.head_item (head_item)
	);

	u8v_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.head_item    (head_item),
		.pop          (pop),
		.valid        (out_valid),
		.stall        (out_stall),
		.string_valid (string_valid)
	);

endmodule

/* tb/utf8_verdict_checker.sv */
// Watches both channels of the UTF-8 validator, predicts each string's verdict and compares it.
module utf8_verdict_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	input  logic       no_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       string_valid,
	output int         failures,
	output int         awaiting
);

	logic [1:0]                 conts_left;
	logic [1:0]                 seq_len;
	logic [u8v_pkg::CODE_W-1:0] code_point;
	logic                       bad_string;
	logic                       want;
	logic                       verdicts[$];

	task automatic absorb_word(input logic [7:0] b, input logic ends, input logic nb);
		if (!nb && !bad_string) begin
			if (conts_left == 2'd0) begin
				if (b >= 8'h80) begin
					if ((b & 8'hE0) == 8'hC0) begin
						code_point = u8v_pkg::CODE_W'(b[4:0]);
						seq_len = u8v_pkg::SEQ_TWO;
					end else if ((b & 8'hF0) == 8'hE0) begin
						code_point = u8v_pkg::CODE_W'(b[3:0]);
						seq_len = u8v_pkg::SEQ_THREE;
					end else if ((b & 8'hF8) == 8'hF0) begin
						code_point = u8v_pkg::CODE_W'(b[2:0]);
						seq_len = u8v_pkg::SEQ_FOUR;
					end else begin
						bad_string = 1'b1;
					end
					if (!bad_string)
						conts_left = seq_len;
				end
			end else if (b[7:6] != 2'b10) begin
				bad_string = 1'b1;
				conts_left = 2'd0;
			end else begin
				code_point = {code_point[u8v_pkg::CODE_W-7:0], b[5:0]};
				conts_left = conts_left - 2'd1;
				if (conts_left == 2'd0) begin
					if ((seq_len == u8v_pkg::SEQ_TWO && code_point < u8v_pkg::MIN_TWO) ||
					    (seq_len == u8v_pkg::SEQ_THREE && code_point < u8v_pkg::MIN_THREE) ||
					    (seq_len == u8v_pkg::SEQ_FOUR && code_point < u8v_pkg::MIN_FOUR) ||
					    code_point > u8v_pkg::CODE_MAX ||
					    (code_point >= u8v_pkg::SURR_LOW &&
					     code_point <= u8v_pkg::SURR_HIGH))
						bad_string = 1'b1;
					seq_len = u8v_pkg::SEQ_NONE;
					code_point = '0;
				end
			end
		end
		if (ends) begin
			verdicts.insert(verdicts.size(), !bad_string && conts_left == 2'd0);
			conts_left = 2'd0;
			seq_len = u8v_pkg::SEQ_NONE;
			code_point = '0;
			bad_string = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conts_left = 2'd0;
			seq_len = u8v_pkg::SEQ_NONE;
			code_point = '0;
			bad_string = 1'b0;
			verdicts.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts.size() == 0) begin
					if (failures < 10)
						$display("[%0t] unexpected word on the output, string_valid %0b",
							$realtime, string_valid);
					failures++;
				end else begin
					want = verdicts.pop_front();
					if (string_valid !== want) begin
						if (failures < 10)
							$display("[%0t] string_valid mismatch: expected %0b, got %0b",
								$realtime, want, string_valid);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_word(data_byte, is_last, no_byte);
		end
		awaiting = verdicts.size();
	end

endmodule

/* tb/utf8_stream_validator_core_tb.sv */
// Stimulus and verdict for the UTF-8 stream validator, with the checker beside the block.
module utf8_stream_validator_core_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       is_last;
	logic       no_byte;
	logic       out_valid;
	logic       out_stall;
	logic       string_valid;
	int         failures;
	int         awaiting;
	int         cycles;
	bit         tx_idle;
	bit         rx_idle;
	int         hold_requests;

	utf8_stream_validator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.is_last(is_last),
		.no_byte(no_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.string_valid(string_valid)
	);

	utf8_verdict_checker verdict_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.is_last(is_last),
		.no_byte(no_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.string_valid(string_valid),
		.failures(failures),
		.awaiting(awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("utf8_stream_validator_core regression: fail");
		$finish;
	end

	initial begin
		int  hold;
		bit  holding;
		int  holds_done;
		out_stall = 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			holding = hold_requests > holds_done;
			if (holding) begin
				hold = LONG_HOLD;
				holds_done++;
			end else
				hold = rx_idle ? $urandom_range(0, 4) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic put(input logic [7:0] b, input logic ends, input logic nb);
		int gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= ends;
		no_byte <= nb;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_string(input logic [7:0] bytes[$], input bit byteless_end);
		for (int i = 0; i < bytes.size(); i++) begin
			if ($urandom_range(0, 19) == 0)
				put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			put(bytes[i], !byteless_end && i == bytes.size() - 1, 1'b0);
		end
		if (byteless_end || bytes.size() == 0)
			put(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] bytes[$];
		int         sent;
		int         strings;
		int         burst;
		int         n_cp;
		bit         byteless_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		is_last = 1'b0;
		no_byte = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_requests = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		put(8'h00, 1'b1, 1'b1);
		send_string('{8'h00, 8'h7F}, 1'b0);
		send_string('{8'hC2, 8'h80, 8'hDF, 8'hBF}, 1'b0);
		send_string('{8'hC0, 8'h80}, 1'b0);
		send_string('{8'hED, 8'hA0, 8'h80}, 1'b0);
		send_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
		send_string('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
		put(8'hFF, 1'b0, 1'b0);
		put(8'hA5, 1'b0, 1'b1);
		put(8'h41, 1'b1, 1'b0);
		send_string('{8'hE2, 8'h82}, 1'b1);
		send_string('{8'hC2, 8'h41}, 1'b0);
		wait_drained();

		sent = 0;
		strings = 0;
		burst = 0;
		while (sent < 900) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if (strings == 40) begin
				hold_requests++;
				burst = 12;
			end
			if (burst > 0) begin
				tx_idle = 1'b0;
				burst--;
			end
			if (strings == 120)
				wait_drained();

			bytes.delete();
			n_cp = $urandom_range(0, 5);
			repeat (n_cp) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: bytes.insert(bytes.size(), 8'($urandom_range(0, 127)));
					4, 5: begin
						bytes.insert(bytes.size(), {3'b110, 5'($urandom_range(0, 31))});
						bytes.insert(bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
					end
					6, 7: begin
						bytes.insert(bytes.size(), {4'b1110, 4'($urandom_range(0, 15))});
						repeat (2)
							bytes.insert(bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
					end
					8: begin
						bytes.insert(bytes.size(), {5'b11110, 3'($urandom_range(0, 4))});
						repeat (3)
							bytes.insert(bytes.size(), {2'b10, 6'($urandom_range(0, 63))});
					end
					default: bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
				endcase
			end
			foreach (bytes[i])
				if ($urandom_range(0, 29) == 0)
					bytes[i] = 8'($urandom_range(0, 255));
			if (bytes.size() > 0 && $urandom_range(0, 9) == 0)
				void'(bytes.pop_back());
			byteless_end = bytes.size() == 0 || $urandom_range(0, 4) == 0;
			send_string(bytes, byteless_end);
			sent += bytes.size() + int'(byteless_end);
			strings++;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (failures == 0 && awaiting == 0)
			$display("utf8_stream_validator_core regression: pass");
		else
			$display("utf8_stream_validator_core regression: fail");
		$finish;
	end

endmodule
